@@ rtl/core/swz_pkg.sv @@
// shared constants and types for the sliding window z-score detector
`default_nettype none
package swz_pkg;
  localparam int MAX_WINDOW  = 256;
  localparam int SAMPLE_BITS = 16;
  localparam int HIST_LEN    = MAX_WINDOW + 1;
  localparam int AW          = $clog2(HIST_LEN);
  localparam int WW          = 9;
  localparam int PW          = 96;
  localparam int MAW         = 64;
  localparam int MBW         = 32;
  localparam int SUM_W       = 25;
  localparam int SQS_W       = 40;
  localparam logic [WW-1:0] W_MIN   = 9'd4;
  localparam logic [WW-1:0] W_MAX   = 9'd256;
  localparam logic [WW-1:0] W_RESET = 9'd128;
  localparam logic [15:0]   SCORE_MAX = 16'hFFFF;

  typedef struct packed {
    logic          start;
    logic [MAW-1:0] a;
    logic [MBW-1:0] b;
  } mul_req_t;
endpackage
`default_nettype wire

@@ rtl/core/sliding_window_zscore_detector_core.sv @@
// top level of the sliding window z-score detector
// Usage: samples enter on in_valid/in_ready/sample_in, one score leaves on
// out_valid/out_ready/score/zero_spread. window_size is written over
// cfg_valid/cfg_ready/cfg_data, always ready; the user must write it only
// while the block is idle, as the block itself does not enforce this.
// Each sample is written to a 257-entry history ram. Until window+1 samples
// are held, a sample gives no result and the block is ready again the next
// cycle. Otherwise the block walks the window through the ram read port,
// then runs five serial multiplies, a check, a restoring divide and a
// square root. When the score saturates the divide and root are skipped;
// with zero spread the last two multiplies, the divide and the root are
// skipped. One sample at a time: no new sample is accepted until the
// previous one is finished. A finished score waits in the output register;
// a new sample is accepted while it waits, and the next score is held back
// until the receiver takes the previous one. Reset empties the history
// count, sets window 128 and drops out_valid; the ram needs no clearing
// since unread entries never matter before they are written.
`default_nettype none
module sliding_window_zscore_detector_core (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic signed [15:0]    sample_in,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [15:0]                score,
  output logic                       zero_spread,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [swz_pkg::WW-1:0] cfg_data
);
  import swz_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_RD     = 7'b0000010,
    S_ACC    = 7'b0000100,
    S_MSTART = 7'b0001000,
    S_MWAIT  = 7'b0010000,
    S_DS     = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t                  state;
  logic [WW-1:0]           window_size;
  logic [WW-1:0]           wc;
  logic [WW-1:0]           w;
  logic [AW-1:0]           wp;
  logic [AW-1:0]           raddr;
  logic [AW:0]             start_sum;
  logic [AW-1:0]           start_addr;
  logic [WW-1:0]           fill;
  logic [WW-1:0]           fill_next;
  logic [WW-1:0]           idx;
  logic signed [15:0]      rdata;
  logic signed [15:0]      c;
  logic signed [SUM_W-1:0] s;
  logic [SQS_W-1:0]        qs;
  logic signed [31:0]      sq;
  logic [2:0]              mstep;
  logic [PW-1:0]           p1;
  logic [PW-1:0]           ev;
  logic [PW-1:0]           rv;
  logic [PW-1:0]           tmp;
  logic [PW-1:0]           mp;
  logic                    mdone;
  mul_req_t                mreq;
  logic [23:0]             s_mag;
  logic signed [25:0]      a_val;
  logic [24:0]             a_mag;
  logic [16:0]             w_sq;
  logic                    ds_start;
  logic                    ds_done;
  logic [15:0]             ds_k;
  logic [15:0]             res_score;
  logic                    res_zero;

  assign in_ready  = state == S_IDLE;
  assign cfg_ready = 1'b1;

  always_comb begin
    if (window_size < W_MIN) begin
      wc = W_MIN;
    end else if (window_size > W_MAX) begin
      wc = W_MAX;
    end else begin
      wc = window_size;
    end
  end

  assign fill_next  = (fill == WW'(HIST_LEN)) ? fill : fill + WW'(1);
  assign start_sum  = (AW+1)'(wp) + (AW+1)'(HIST_LEN) - (AW+1)'(wc);
  assign start_addr = (start_sum >= (AW+1)'(HIST_LEN)) ?
                      AW'(start_sum - (AW+1)'(HIST_LEN)) : AW'(start_sum);
  assign sq    = rdata * rdata;
  assign s_mag = s[SUM_W-1] ? 24'(-s) : 24'(s);
  assign a_val = c * $signed({1'b0, w}) - 26'(s);
  assign a_mag = a_val[25] ? 25'(-a_val) : 25'(a_val);
  assign w_sq  = 17'(w) * 17'(w);

  swz_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(HIST_LEN)) u_hist (
    .clk   (clk),
    .we    (in_valid && in_ready),
    .waddr (wp),
    .wdata (sample_in),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    mreq.start = state == S_MSTART;
    mreq.a     = '0;
    mreq.b     = '0;
    unique case (mstep)
      3'd0: begin
        mreq.a = MAW'(qs);
        mreq.b = MBW'(w_sq);
      end
      3'd1: begin
        mreq.a = MAW'(s_mag);
        mreq.b = MBW'(s_mag);
      end
      3'd2: begin
        mreq.a = tmp[MAW-1:0];
        mreq.b = MBW'(w) + MBW'(1);
      end
      3'd3: begin
        mreq.a = MAW'(a_mag);
        mreq.b = MBW'(a_mag);
      end
      3'd4: begin
        mreq.a = tmp[MAW-1:0];
        mreq.b = MBW'(w) + MBW'(1);
      end
      default: begin
        mreq.a = '0;
        mreq.b = '0;
      end
    endcase
  end

  swz_serial_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .done (mdone),
    .p    (mp)
  );

  swz_divsqrt u_ds (
    .clk   (clk),
    .rst   (rst),
    .start (ds_start),
    .e     (ev),
    .r     (rv),
    .done  (ds_done),
    .k     (ds_k)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      window_size <= W_RESET;
      wp          <= '0;
      fill        <= '0;
      out_valid   <= 1'b0;
      ds_start    <= 1'b0;
      mstep       <= '0;
    end else begin
      ds_start <= state == S_MWAIT && mdone && mstep == 3'd4;
      if (cfg_valid && cfg_ready) begin
        window_size <= cfg_data;
      end
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            raddr <= start_addr;
            wp    <= (wp == AW'(HIST_LEN - 1)) ? '0 : wp + AW'(1);
            fill  <= fill_next;
            w     <= wc;
            if (fill_next >= wc + WW'(1)) begin
              state <= S_RD;
              idx   <= '0;
              s     <= '0;
              qs    <= '0;
              mstep <= '0;
            end
          end
        end
        S_RD: begin
          state <= S_ACC;
        end
        S_ACC: begin
          if (idx == (w >> 1)) begin
            c <= rdata;
          end else begin
            s  <= s + SUM_W'(rdata);
            qs <= qs + SQS_W'(unsigned'(sq));
          end
          raddr <= (raddr == AW'(HIST_LEN - 1)) ? '0 : raddr + AW'(1);
          idx   <= idx + WW'(1);
          state <= (idx == w - WW'(1)) ? S_MSTART : S_RD;
        end
        S_MSTART: begin
          state <= S_MWAIT;
        end
        S_MWAIT: begin
          if (mdone) begin
            mstep <= mstep + 3'd1;
            unique case (mstep)
              3'd0: begin
                p1    <= mp;
                state <= S_MSTART;
              end
              3'd1: begin
                tmp   <= mp;
                state <= S_MSTART;
              end
              3'd2: begin
                ev <= p1 - mp;
                if (p1 == mp) begin
                  res_score <= SCORE_MAX;
                  res_zero  <= 1'b1;
                  state     <= S_DONE;
                end else begin
                  state <= S_MSTART;
                end
              end
              3'd3: begin
                tmp   <= mp;
                state <= S_MSTART;
              end
              3'd4: begin
                rv    <= mp << 16;
                state <= S_DS;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_DS: begin
          if (ds_done) begin
            res_score <= ds_k;
            res_zero  <= 1'b0;
            state     <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            score       <= res_score;
            zero_spread <= res_zero;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_zero_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_spread |-> score == SCORE_MAX)
    else $error("zero spread without saturated score");

  a_acc_filled: assert property (@(posedge clk) disable iff (rst)
    state == S_ACC |-> fill >= w + WW'(1))
    else $error("window walk before history filled");

  a_rise_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result raised outside completion");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_RD |-> idx < w)
    else $error("window index overrun");
endmodule
`default_nettype wire

@@ rtl/core/swz_ram.sv @@
// generic single write, single registered read ram
`default_nettype none
module swz_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 257
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/core/swz_serial_mul.sv @@
// bit serial shift and add multiplier, one multiplier bit per cycle
`default_nettype none
module swz_serial_mul (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire swz_pkg::mul_req_t req,
  output logic                  done,
  output logic [swz_pkg::PW-1:0] p
);
  import swz_pkg::*;

  logic [PW-1:0]  areg;
  logic [MBW-1:0] breg;
  logic [5:0]     cnt;
  logic           busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !req.start && cnt == 6'd1;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 6'(MBW);
        p    <= '0;
        areg <= PW'(req.a);
        breg <= req.b;
      end else if (busy) begin
        if (breg[0]) begin
          p <= p + areg;
        end
        areg <= areg << 1;
        breg <= breg >> 1;
        cnt  <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/swz_divsqrt.sv @@
// restoring divide of r by e then bitwise integer square root; k saturates when the quotient would not fit 32 bits
`default_nettype none
module swz_divsqrt (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [swz_pkg::PW-1:0] e,
  input  wire logic [swz_pkg::PW-1:0] r,
  output logic                       done,
  output logic [15:0]                k
);
  import swz_pkg::*;

  typedef enum logic [3:0] {
    D_IDLE = 4'b0001,
    D_CHK  = 4'b0010,
    D_DIV  = 4'b0100,
    D_SQ   = 4'b1000
  } dstate_t;

  dstate_t       state;
  logic [PW-1:0] rem;
  logic [PW-1:0] d;
  logic [31:0]   q;
  logic [4:0]    cnt;
  logic [3:0]    bitp;
  logic [15:0]   t;
  logic [31:0]   tsq;
  logic          ge;

  assign t   = k | (16'd1 << bitp);
  assign tsq = t * t;
  assign ge  = rem >= d;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == D_CHK && r >= (e << 32)) || (state == D_SQ && bitp == 4'd0);
      unique case (state)
        D_IDLE: begin
          if (start) begin
            state <= D_CHK;
          end
        end
        D_CHK: begin
          if (r >= (e << 32)) begin
            k     <= SCORE_MAX;
            state <= D_IDLE;
          end else begin
            rem   <= r;
            d     <= e << 31;
            q     <= '0;
            cnt   <= 5'd31;
            state <= D_DIV;
          end
        end
        D_DIV: begin
          if (ge) begin
            rem <= rem - d;
          end
          q   <= {q[30:0], ge};
          d   <= d >> 1;
          cnt <= cnt - 5'd1;
          if (cnt == 5'd0) begin
            k     <= '0;
            bitp  <= 4'd15;
            state <= D_SQ;
          end
        end
        D_SQ: begin
          if (tsq <= q) begin
            k <= t;
          end
          bitp <= bitp - 4'd1;
          if (bitp == 4'd0) begin
            state <= D_IDLE;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
